FILE: design/clni_pkg.sv
// ----------------------------------------------------------------------------
// clni_pkg
// Types, codes and constants shared by the character LCD nibble interface.
// ----------------------------------------------------------------------------
package clni_pkg;

    localparam int HOLD_W    = 24;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 24;

    localparam logic [HOLD_W-1:0] HOLD_MAX = 24'hFFFFFF;

    // register reset values
    localparam logic [23:0] RST_POWER_UP_WAIT   = 24'd200000;
    localparam logic [23:0] RST_NIBBLE_WAIT     = 24'd250;
    localparam logic [23:0] RST_POST_WRITE_WAIT = 24'd5000;
    localparam logic [7:0]  RST_ENABLE_WIDTH    = 8'd1;

    // init sequence constants
    localparam logic [3:0] NIB_INIT_A = 4'h3;
    localparam logic [3:0] NIB_INIT_B = 4'h2;
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_FUNC   = 8'h28;
    localparam logic [7:0] CMD_DISP   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY  = 8'h06;

    typedef enum logic [1:0] {
        OP_CMD  = 2'd0,
        OP_DATA = 2'd1,
        OP_INIT = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POWER_UP_WAIT   = 4'd0,
        REG_NIBBLE_WAIT     = 4'd1,
        REG_POST_WRITE_WAIT = 4'd2,
        REG_ENABLE_WIDTH    = 4'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POWER,
        ST_NIBBLE,
        ST_BYTE
    } t_state;

    typedef struct packed {
        logic [23:0] power_up_wait;
        logic [23:0] nibble_wait;
        logic [23:0] post_write_wait;
        logic [7:0]  enable_width;
    } t_cfg;

    typedef struct packed {
        t_state      state;
        logic [1:0]  idx;
        logic [1:0]  sub;
        logic        init;
        logic [7:0]  byte_val;
        logic        byte_rs;
        logic        rs_level;
    } t_step;

    typedef struct packed {
        logic [3:0]        nibble;
        logic              rs;
        logic              en;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } t_event;

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] cmd;
        unique case (idx)
            2'd0: cmd = CMD_FUNC;
            2'd1: cmd = CMD_DISP;
            2'd2: cmd = CMD_CLEAR;
            2'd3: cmd = CMD_ENTRY;
            default: cmd = CMD_FUNC;
        endcase
        return cmd;
    endfunction

endpackage

FILE: design/clni_if.sv
// ----------------------------------------------------------------------------
// clni channel interfaces
// Valid/ready channels for op items, pin event items and register writes.
// ----------------------------------------------------------------------------
interface clni_in_if
    import clni_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface clni_out_if
    import clni_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [3:0]        bus_nibble;
    logic              reg_select;
    logic              enable_line;
    logic [HOLD_W-1:0] hold_ticks;
    logic              last;

    modport source (output valid, output bus_nibble, output reg_select,
                    output enable_line, output hold_ticks, output last, input ready);
    modport sink   (input valid, input bus_nibble, input reg_select,
                    input enable_line, input hold_ticks, input last, output ready);
endinterface

interface clni_cfg_if
    import clni_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/clni_event_unit.sv
// ----------------------------------------------------------------------------
// clni_event_unit
// Shared event generator: pin levels and saturated hold for one sequencer step.
// ----------------------------------------------------------------------------
module clni_event_unit
    import clni_pkg::*;
#(
    parameter int TIMER_WIDTH = 24
) (
    input  t_step  i_step,
    input  t_cfg   i_cfg,
    output t_event o_event
);

    localparam logic [HOLD_W:0] HOLD_LIMIT = (TIMER_WIDTH >= HOLD_W) ?
        {1'b0, HOLD_MAX} : (HOLD_W+1)'((33'd1 << TIMER_WIDTH) - 33'd1);

    logic [HOLD_W:0] raw_hold;
    logic            is_clear;

    always_comb begin
        o_event  = '0;
        raw_hold = '0;
        is_clear = !i_step.byte_rs && (i_step.byte_val == CMD_CLEAR);
        unique case (i_step.state)
            ST_POWER: begin
                o_event.nibble = 4'h0;
                o_event.rs     = i_step.rs_level;
                o_event.en     = 1'b0;
                raw_hold       = {1'b0, i_step.state == ST_POWER ? i_cfg.power_up_wait : 24'd0};
            end
            ST_NIBBLE: begin
                o_event.nibble = (i_step.idx == 2'd3) ? NIB_INIT_B : NIB_INIT_A;
                o_event.rs     = 1'b0;
                o_event.en     = ~i_step.sub[0];
                raw_hold       = i_step.sub[0] ? {1'b0, i_cfg.nibble_wait}
                                               : {17'd0, i_cfg.enable_width};
            end
            ST_BYTE: begin
                o_event.nibble = i_step.sub[1] ? i_step.byte_val[3:0] : i_step.byte_val[7:4];
                o_event.rs     = i_step.byte_rs;
                o_event.en     = ~i_step.sub[0];
                o_event.last   = (i_step.sub == 2'd3) && (!i_step.init || i_step.idx == 2'd3);
                unique case (i_step.sub)
                    2'd0, 2'd2: raw_hold = {17'd0, i_cfg.enable_width};
                    2'd1:       raw_hold = '0;
                    2'd3: begin
                        // clear command needs twice the settle time
                        raw_hold = is_clear ? {i_cfg.post_write_wait, 1'b0}
                                            : {1'b0, i_cfg.post_write_wait};
                    end
                    default:    raw_hold = '0;
                endcase
            end
            ST_IDLE: begin
                o_event = '0;
            end
            default: o_event = '0;
        endcase
        o_event.hold = (raw_hold > HOLD_LIMIT) ? HOLD_LIMIT[HOLD_W-1:0] : raw_hold[HOLD_W-1:0];
    end

endmodule

FILE: design/char_lcd_nibble_interface_unit.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_interface_unit
// 4-bit character LCD controller: turns command, data and init requests into
// timed pin events for the data lines, register select and enable.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  i_in      in   valid / ready   op, value
//  o_out     out  valid / ready   bus_nibble, reg_select, enable_line,
//                                 hold_ticks, last
//  i_cfg     in   valid / ready   index, data (always ready)
//
//  a byte write gives 4 events, init gives 25; the step sequencer makes one
//  event per cycle through the shared event unit while the output register
//  is empty or o_out.ready is high
//  the output register holds an event while o_out.ready is low and the
//  sequencer stalls; i_in.ready is high only when the sequencer is idle
//  reset (synchronous, active low) loads the register defaults and idles
// ----------------------------------------------------------------------------
module char_lcd_nibble_interface_unit
    import clni_pkg::*;
#(
    parameter int TIMER_WIDTH = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clni_in_if.sink    i_in,
    clni_out_if.source o_out,
    clni_cfg_if.sink   i_cfg
);

    t_state     r_state,    n_state;
    logic [1:0] r_idx,      n_idx;
    logic [1:0] r_sub,      n_sub;
    logic       r_init,     n_init;
    logic [7:0] r_byte_val, n_byte_val;
    logic       r_byte_rs,  n_byte_rs;
    logic       r_rs_level, n_rs_level;
    logic       r_ov,       n_ov;
    t_event     r_ev;
    t_cfg       r_cfg;

    t_step      step;
    t_event     ev;
    logic       gen;
    logic       in_acc;

    assign step = '{state: r_state, idx: r_idx, sub: r_sub, init: r_init,
                    byte_val: r_byte_val, byte_rs: r_byte_rs, rs_level: r_rs_level};

    clni_event_unit #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_event (
        .i_step  (step),
        .i_cfg   (r_cfg),
        .o_event (ev)
    );

    assign gen    = (r_state != ST_IDLE) && (!r_ov || o_out.ready);
    assign in_acc = i_in.valid && i_in.ready;

    // next state
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_sub      = r_sub;
        n_init     = r_init;
        n_byte_val = r_byte_val;
        n_byte_rs  = r_byte_rs;
        n_rs_level = r_rs_level;
        n_ov       = r_ov;
        if (o_out.ready) begin
            n_ov = 1'b0;
        end
        if (gen) begin
            n_ov = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_idx = 2'd0;
                    n_sub = 2'd0;
                    unique case (t_op'(i_in.op))
                        OP_CMD, OP_DATA: begin
                            n_state    = ST_BYTE;
                            n_init     = 1'b0;
                            n_byte_val = i_in.value;
                            n_byte_rs  = i_in.op[0];
                            n_rs_level = i_in.op[0];
                        end
                        OP_INIT: begin
                            n_state = ST_POWER;
                            n_init  = 1'b1;
                        end
                        OP_NONE: n_state = ST_IDLE;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_POWER: begin
                if (gen) begin
                    n_state = ST_NIBBLE;
                    n_idx   = 2'd0;
                    n_sub   = 2'd0;
                end
            end
            ST_NIBBLE: begin
                if (gen) begin
                    if (!r_sub[0]) begin
                        n_sub = 2'd1;
                    end else if (r_idx == 2'd3) begin
                        // bare nibbles done, go on to the init commands
                        n_state    = ST_BYTE;
                        n_idx      = 2'd0;
                        n_sub      = 2'd0;
                        n_byte_val = init_cmd(2'd0);
                        n_byte_rs  = 1'b0;
                        n_rs_level = 1'b0;
                    end else begin
                        n_idx = r_idx + 2'd1;
                        n_sub = 2'd0;
                    end
                end
            end
            ST_BYTE: begin
                if (gen) begin
                    if (r_sub != 2'd3) begin
                        n_sub = r_sub + 2'd1;
                    end else if (r_init && r_idx != 2'd3) begin
                        n_idx      = r_idx + 2'd1;
                        n_sub      = 2'd0;
                        n_byte_val = init_cmd(r_idx + 2'd1);
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready        = (r_state == ST_IDLE);
        i_cfg.ready       = 1'b1;
        o_out.valid       = r_ov;
        o_out.bus_nibble  = r_ev.nibble;
        o_out.reg_select  = r_ev.rs;
        o_out.enable_line = r_ev.en;
        o_out.hold_ticks  = r_ev.hold;
        o_out.last        = r_ev.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= 2'd0;
            r_sub      <= 2'd0;
            r_init     <= 1'b0;
            r_byte_rs  <= 1'b0;
            r_rs_level <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_sub      <= n_sub;
            r_init     <= n_init;
            r_byte_rs  <= n_byte_rs;
            r_rs_level <= n_rs_level;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte_val <= n_byte_val;
        if (gen) begin
            r_ev <= ev;
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_up_wait   <= RST_POWER_UP_WAIT;
            r_cfg.nibble_wait     <= RST_NIBBLE_WAIT;
            r_cfg.post_write_wait <= RST_POST_WRITE_WAIT;
            r_cfg.enable_width    <= RST_ENABLE_WIDTH;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_POWER_UP_WAIT:   r_cfg.power_up_wait   <= i_cfg.data;
                REG_NIBBLE_WAIT:     r_cfg.nibble_wait     <= i_cfg.data;
                REG_POST_WRITE_WAIT: r_cfg.post_write_wait <= i_cfg.data;
                REG_ENABLE_WIDTH:    r_cfg.enable_width    <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    a_last_ends_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (gen && ev.last) |=> (r_state == ST_IDLE))
        else $error("sequencer still busy after final event");

    a_init_starts_power : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.op == OP_INIT) |=> (r_state == ST_POWER))
        else $error("init item did not start with power-up wait");

    a_init_cmds_rs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_init && r_state == ST_BYTE) |-> (!r_byte_rs && !r_rs_level))
        else $error("init command written with register select high");

    a_no_event_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !r_ov) |=> !r_ov)
        else $error("event appeared without an active item");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the char LCD nibble interface: a queue-fed driver
// offers op items, a clocked monitor checks every pin event against a
// predictor kept in step with register writes, under several idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import clni_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 88;

    typedef struct packed {
        t_op        op;
        logic [7:0] value;
    } t_lcd_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    clni_in_if  in_ch ();
    clni_out_if out_ch ();
    clni_cfg_if cfg_ch ();

    char_lcd_nibble_interface_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_lcd_req pend_q[$];
    t_lcd_req cur_req;
    t_event   pin_events_q[$];
    t_cfg     cfg_mirror;
    logic     rs_mirror;

    int  src_idle_pct;
    int  sink_stall_pct;
    int  n_fail = 0;
    int  idle_cycles;
    int  hold_cnt;
    logic hold_req;
    logic hold_on;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------

    task automatic push_pin(input logic [3:0] nib, input logic rs, input logic en,
                            input logic [HOLD_W-1:0] hold);
        t_event ev;
        ev.nibble = nib;
        ev.rs     = rs;
        ev.en     = en;
        ev.hold   = hold;
        ev.last   = 1'b0;
        pin_events_q.push_back(ev);
    endtask

    task automatic queue_nibble(input logic [3:0] nib, input logic rs,
                                input logic [HOLD_W-1:0] after);
        push_pin(nib, rs, 1'b1, HOLD_W'(cfg_mirror.enable_width));
        push_pin(nib, rs, 1'b0, after);
    endtask

    task automatic queue_byte_write(input logic [7:0] b, input logic rs);
        logic [HOLD_W:0] tail;
        tail = {1'b0, cfg_mirror.post_write_wait};
        // clear command gets twice the settle time, saturating
        if (!rs && b == CMD_CLEAR)
            tail = tail << 1;
        if (tail > {1'b0, HOLD_MAX})
            tail = {1'b0, HOLD_MAX};
        rs_mirror = rs;
        queue_nibble(b[7:4], rs, '0);
        queue_nibble(b[3:0], rs, tail[HOLD_W-1:0]);
    endtask

    task automatic predict_pins(input t_lcd_req r);
        int     first;
        t_event ev;
        first = pin_events_q.size();
        case (r.op)
            OP_CMD: begin
                queue_byte_write(r.value, 1'b0);
            end
            OP_DATA: begin
                queue_byte_write(r.value, 1'b1);
            end
            OP_INIT: begin
                push_pin(4'h0, rs_mirror, 1'b0, cfg_mirror.power_up_wait);
                for (int i = 0; i < 3; i++)
                    queue_nibble(NIB_INIT_A, 1'b0, cfg_mirror.nibble_wait);
                queue_nibble(NIB_INIT_B, 1'b0, cfg_mirror.nibble_wait);
                rs_mirror = 1'b0;
                queue_byte_write(CMD_FUNC, 1'b0);
                queue_byte_write(CMD_DISP, 1'b0);
                queue_byte_write(CMD_CLEAR, 1'b0);
                queue_byte_write(CMD_ENTRY, 1'b0);
            end
            default: ;
        endcase
        if (pin_events_q.size() > first) begin
            ev = pin_events_q[pin_events_q.size()-1];
            ev.last = 1'b1;
            pin_events_q[pin_events_q.size()-1] = ev;
        end
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                predict_pins(cur_req);
            if (!in_ch.valid || in_ch.ready) begin
                if (pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_req = pend_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.op    <= cur_req.op;
                    in_ch.value <= cur_req.value;
                end else begin
                    // junk on the payload while idle
                    in_ch.valid <= 1'b0;
                    in_ch.op    <= 2'($urandom);
                    in_ch.value <= 8'($urandom);
                end
            end
        end
    end

    // ---------------- long receiver hold-off ----------------

    always @(posedge i_clk) begin
        if (!hold_req)
            hold_cnt <= 0;
        else if (hold_cnt < HOLD_CYCLES)
            hold_cnt <= hold_cnt + 1;
    end

    assign hold_on = hold_req && (hold_cnt < HOLD_CYCLES);

    // ---------------- monitor ----------------

    task automatic check_field(input string name, input logic [HOLD_W-1:0] want,
                               input logic [HOLD_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin : mon
        t_event want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pin_events_q.size() == 0) begin
                    $error("unexpected pin event: nibble %0h rs %0b en %0b hold %0h",
                           out_ch.bus_nibble, out_ch.reg_select, out_ch.enable_line,
                           out_ch.hold_ticks);
                    n_fail++;
                end else begin
                    want = pin_events_q.pop_front();
                    check_field("bus_nibble", HOLD_W'(want.nibble), HOLD_W'(out_ch.bus_nibble));
                    check_field("reg_select", HOLD_W'(want.rs), HOLD_W'(out_ch.reg_select));
                    check_field("enable_line", HOLD_W'(want.en), HOLD_W'(out_ch.enable_line));
                    check_field("hold_ticks", want.hold, out_ch.hold_ticks);
                    check_field("last", HOLD_W'(want.last), HOLD_W'(out_ch.last));
                end
            end
            out_ch.ready <= !hold_on && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("char_lcd_nibble_interface_unit test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------

    task automatic queue_item(input t_op op, input logic [7:0] v);
        t_lcd_req r;
        r.op    = op;
        r.value = v;
        pend_q.push_back(r);
    endtask

    task automatic queue_random_item();
        int   pick;
        t_op  op;
        logic [7:0] v;
        pick = $urandom_range(99);
        if (pick < 42)
            op = OP_CMD;
        else if (pick < 84)
            op = OP_DATA;
        else if (pick < 94)
            op = OP_INIT;
        else
            op = OP_NONE;
        v = ($urandom_range(9) == 0) ? CMD_CLEAR : 8'($urandom);
        queue_item(op, v);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_POWER_UP_WAIT:   cfg_mirror.power_up_wait   = d;
            REG_NIBBLE_WAIT:     cfg_mirror.nibble_wait     = d;
            REG_POST_WRITE_WAIT: cfg_mirror.post_write_wait = d;
            REG_ENABLE_WIDTH:    cfg_mirror.enable_width    = d[7:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_unused_reg();
        write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_ENABLE_WIDTH + 1)),
                  CFG_DAT_W'($urandom));
    endtask

    // block idle: nothing pending, nothing owed, then room for a dropped op
    task automatic drain();
        do @(negedge i_clk);
        while (pend_q.size() != 0 || in_ch.valid || pin_events_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_settings(input int p);
        case (p)
            0: begin
                // everything at the top, doubled clear wait saturates
                write_reg(REG_POWER_UP_WAIT, HOLD_MAX);
                write_reg(REG_NIBBLE_WAIT, HOLD_MAX);
                write_reg(REG_POST_WRITE_WAIT, HOLD_MAX);
                write_reg({CFG_IDX_W{1'b1}}, CFG_DAT_W'($urandom));
                write_reg(REG_ENABLE_WIDTH, {CFG_DAT_W{1'b1}});
            end
            1: begin
                // all zero, enable width truncated down to zero
                write_reg(REG_POWER_UP_WAIT, '0);
                write_reg(REG_NIBBLE_WAIT, '0);
                write_reg(REG_POST_WRITE_WAIT, '0);
                write_reg(REG_ENABLE_WIDTH, 24'hFFFF00);
                write_unused_reg();
            end
            2: begin
                // upper half post wait: doubling overflows unless clamped
                write_reg(REG_POWER_UP_WAIT, CFG_DAT_W'($urandom));
                write_reg(REG_NIBBLE_WAIT, CFG_DAT_W'($urandom));
                write_reg(REG_POST_WRITE_WAIT, 24'h800000 | CFG_DAT_W'($urandom));
                write_reg(REG_ENABLE_WIDTH, CFG_DAT_W'($urandom));
                write_unused_reg();
            end
            3: begin
                write_reg(REG_ENABLE_WIDTH, CFG_DAT_W'($urandom));
                write_reg(REG_POST_WRITE_WAIT, CFG_DAT_W'($urandom_range(24'h7FFFFF)));
                write_unused_reg();
                write_reg(REG_NIBBLE_WAIT, CFG_DAT_W'($urandom_range(1000)));
                write_reg(REG_POWER_UP_WAIT, CFG_DAT_W'($urandom));
            end
            default: begin
                write_reg(REG_POWER_UP_WAIT, RST_POWER_UP_WAIT);
                write_reg(REG_NIBBLE_WAIT, RST_NIBBLE_WAIT);
                write_reg(REG_POST_WRITE_WAIT, RST_POST_WRITE_WAIT);
                write_reg(REG_ENABLE_WIDTH, CFG_DAT_W'(RST_ENABLE_WIDTH));
            end
        endcase
    endtask

    initial begin
        in_ch.valid   = 1'b0;
        in_ch.op      = OP_NONE;
        in_ch.value   = '0;
        out_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        hold_req       = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        idle_cycles    = 0;
        hold_cnt       = 0;
        cfg_mirror.power_up_wait   = RST_POWER_UP_WAIT;
        cfg_mirror.nibble_wait     = RST_NIBBLE_WAIT;
        cfg_mirror.post_write_wait = RST_POST_WRITE_WAIT;
        cfg_mirror.enable_width    = RST_ENABLE_WIDTH;
        rs_mirror = 1'b0;
        i_rst_n   = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed items on reset settings
        @(negedge i_clk);
        queue_item(OP_CMD, 8'h00);
        queue_item(OP_CMD, 8'hFF);
        queue_item(OP_CMD, CMD_CLEAR);
        queue_item(OP_DATA, CMD_CLEAR);   // data byte 0x01 is not doubled
        queue_item(OP_DATA, 8'hFF);
        queue_item(OP_DATA, 8'h00);
        queue_item(OP_INIT, 8'h00);       // power-up event keeps rs from data
        queue_item(OP_DATA, 8'hA5);
        queue_item(OP_NONE, 8'hFF);       // dropped, rs level unchanged
        queue_item(OP_INIT, 8'hFF);
        queue_item(OP_INIT, 8'h5A);
        queue_item(OP_CMD, 8'h5A);
        queue_item(OP_NONE, 8'h00);
        queue_item(OP_DATA, 8'h3C);
        queue_item(OP_CMD, CMD_CLEAR);
        queue_item(OP_INIT, 8'h01);
        drain();

        for (int p = 0; p < 5; p++) begin
            load_settings(p);
            @(negedge i_clk);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
                default: begin src_idle_pct = 8; sink_stall_pct = 8; end
            endcase
            // last phase: receiver backs off while items keep coming
            hold_req = (p == 4);
            repeat (PHASE_ITEMS) queue_random_item();
            drain();
            hold_req = 1'b0;
        end

        if (n_fail == 0)
            $display("char_lcd_nibble_interface_unit test passed");
        else
            $display("char_lcd_nibble_interface_unit test failed");
        $finish;
    end

endmodule
